// ===== hdl/wclp_pkg.sv =====
// Shared types and constants for the WRITE command line parser.
// Holds the status codes, parser phases, result word layout and character codes.
// No dependencies.
`timescale 1ns / 1ps

package wclp_pkg;

  // Line outcome codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_WRITE = 2'd1,
    ST_NO_BLOCK  = 2'd2,
    ST_SHORT_HEX = 2'd3
  } wclp_status_t;

  // Parser phases
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_TAG   = 3'd1,
    PH_NUMWS = 3'd2,
    PH_NUM   = 3'd3,
    PH_HEXWS = 3'd4,
    PH_HEX   = 3'd5,
    PH_DONE  = 3'd6
  } wclp_phase_t;

  // One result word
  typedef struct packed {
    wclp_status_t       status;
    logic signed [15:0] block;
    logic [63:0]        data_high;
    logic [63:0]        data_low;
  } wclp_result_t;

  localparam logic [2:0]  TAG_LEN    = 3'd5;
  localparam logic [5:0]  HEX_DIGITS = 6'd32;
  localparam logic [16:0] MAG_LIMIT  = 17'd32768;
  localparam logic [16:0] POS_MAX    = 17'd32767;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;

  // Expected character of the tag WRITE at a position
  function automatic logic [7:0] tag_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h57; // W
      3'd1:    c = 8'h52; // R
      3'd2:    c = 8'h49; // I
      3'd3:    c = 8'h54; // T
      3'd4:    c = 8'h45; // E
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/wclp_parser.sv =====
// Character-at-a-time parser state and next-state logic for the WRITE command.
// Depends on wclp_pkg for phases, status codes, character codes and the result word.
`timescale 1ns / 1ps

module wclp_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  take,
  input  logic [7:0]            ch,
  input  logic                  last,
  output wclp_pkg::wclp_result_t res
);
  import wclp_pkg::*;

  wclp_phase_t  phase_r, phase_nxt;
  logic [2:0]   tag_pos_r, tag_pos_nxt;
  logic         neg_r, neg_nxt;
  logic         digit_seen_r, digit_seen_nxt;
  logic [16:0]  acc_r, acc_nxt;
  logic [5:0]   hex_cnt_r, hex_cnt_nxt;
  logic [63:0]  dh_r, dh_nxt;
  logic [63:0]  dl_r, dl_nxt;
  wclp_status_t line_st_r, line_st_nxt;

  // Outcome when the text ends in a given phase
  function automatic wclp_status_t fin_status(input wclp_phase_t ph, input logic [2:0] tp,
                                              input logic ds);
    wclp_status_t s;
    case (ph)
      PH_LEAD:  s = ST_NOT_WRITE;
      PH_TAG:   s = (tp >= TAG_LEN) ? ST_NO_BLOCK : ST_NOT_WRITE;
      PH_NUMWS: s = ST_NO_BLOCK;
      PH_NUM:   s = ds ? ST_SHORT_HEX : ST_NO_BLOCK;
      default:  s = ST_SHORT_HEX;
    endcase
    return s;
  endfunction

  // Consume one character, then close the line if it is the last one
  always_comb begin
    logic        go_num;
    logic        go_hexws;
    logic        go_hex;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [18:0] m;
    logic [15:0] blk;

    phase_nxt      = phase_r;
    tag_pos_nxt    = tag_pos_r;
    neg_nxt        = neg_r;
    digit_seen_nxt = digit_seen_r;
    acc_nxt        = acc_r;
    hex_cnt_nxt    = hex_cnt_r;
    dh_nxt         = dh_r;
    dl_nxt         = dl_r;
    line_st_nxt    = line_st_r;
    go_num         = 1'b0;
    go_hexws       = 1'b0;
    go_hex         = 1'b0;
    m              = 19'(acc_r) * 19'd10 + 19'(ch[3:0]);
    blk            = 16'd0;
    res            = '0;

    // Classify the character as a hex digit
    hex_ok  = 1'b1;
    hex_val = ch[3:0];
    if (ch inside {[CH_0:CH_9]}) begin
      hex_val = ch[3:0];
    end else if (ch inside {[CH_UA:CH_UF], [CH_LA:CH_LF_HEX]}) begin
      hex_val = ch[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end

    if (take && phase_r != PH_DONE) begin
      if (ch == CH_NUL) begin
        line_st_nxt = fin_status(phase_r, tag_pos_r, digit_seen_r);
        phase_nxt   = PH_DONE;
      end else begin
        case (phase_r)
          PH_LEAD: begin
            if (ch inside {CH_SPACE, CH_TAB}) begin
              phase_nxt = PH_LEAD;
            end else if (ch == tag_char(3'd0)) begin
              tag_pos_nxt = 3'd1;
              phase_nxt   = PH_TAG;
            end else begin
              line_st_nxt = ST_NOT_WRITE;
              phase_nxt   = PH_DONE;
            end
          end
          PH_TAG: begin
            if (tag_pos_r < TAG_LEN) begin
              if (ch == tag_char(tag_pos_r)) begin
                tag_pos_nxt = tag_pos_r + 3'd1;
              end else begin
                line_st_nxt = ST_NOT_WRITE;
                phase_nxt   = PH_DONE;
              end
            end else if (ch inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
              phase_nxt = PH_NUMWS;
            end else begin
              line_st_nxt = ST_NOT_WRITE;
              phase_nxt   = PH_DONE;
            end
          end
          PH_NUMWS: begin
            if (ch inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
              phase_nxt = PH_NUMWS;
            end else if (ch inside {CH_PLUS, CH_MINUS}) begin
              neg_nxt   = (ch == CH_MINUS);
              phase_nxt = PH_NUM;
            end else begin
              go_num = 1'b1;
            end
          end
          PH_NUM:   go_num   = 1'b1;
          PH_HEXWS: go_hexws = 1'b1;
          PH_HEX:   go_hex   = 1'b1;
          default:  phase_nxt = phase_r;
        endcase

        // Decimal digits of the block number, magnitude saturating
        if (go_num) begin
          phase_nxt = PH_NUM;
          if (ch inside {[CH_0:CH_9]}) begin
            acc_nxt        = (m > 19'(MAG_LIMIT)) ? MAG_LIMIT : m[16:0];
            digit_seen_nxt = 1'b1;
          end else if (!digit_seen_r) begin
            line_st_nxt = ST_NO_BLOCK;
            phase_nxt   = PH_DONE;
          end else begin
            go_hexws = 1'b1;
          end
        end

        // Blanks ahead of the hex data
        if (go_hexws) begin
          phase_nxt = PH_HEXWS;
          if (!(ch inside {CH_SPACE, CH_TAB})) begin
            go_hex = 1'b1;
          end
        end

        // Shift in one hex digit
        if (go_hex) begin
          if (!hex_ok) begin
            line_st_nxt = ST_SHORT_HEX;
            phase_nxt   = PH_DONE;
          end else begin
            dh_nxt      = {dh_r[59:0], dl_r[63:60]};
            dl_nxt      = {dl_r[59:0], hex_val};
            hex_cnt_nxt = hex_cnt_r + 6'd1;
            if (hex_cnt_nxt >= HEX_DIGITS) begin
              line_st_nxt = ST_OK;
              phase_nxt   = PH_DONE;
            end else begin
              phase_nxt = PH_HEX;
            end
          end
        end
      end
    end

    // Close the line: form the result and return to the reset state
    if (take && last) begin
      if (phase_nxt != PH_DONE) begin
        line_st_nxt = fin_status(phase_nxt, tag_pos_nxt, digit_seen_nxt);
      end
      if (line_st_nxt == ST_OK || line_st_nxt == ST_SHORT_HEX) begin
        if (neg_nxt) begin
          blk = ~acc_nxt[15:0] + 16'd1;
        end else begin
          blk = (acc_nxt > POS_MAX) ? POS_MAX[15:0] : acc_nxt[15:0];
        end
      end
      res.status    = line_st_nxt;
      res.block     = blk;
      res.data_high = (line_st_nxt == ST_OK) ? dh_nxt : 64'd0;
      res.data_low  = (line_st_nxt == ST_OK) ? dl_nxt : 64'd0;

      phase_nxt      = PH_LEAD;
      tag_pos_nxt    = 3'd0;
      neg_nxt        = 1'b0;
      digit_seen_nxt = 1'b0;
      acc_nxt        = 17'd0;
      hex_cnt_nxt    = 6'd0;
      dh_nxt         = 64'd0;
      dl_nxt         = 64'd0;
      line_st_nxt    = ST_OK;
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_LEAD;
      tag_pos_r    <= 3'd0;
      neg_r        <= 1'b0;
      digit_seen_r <= 1'b0;
      acc_r        <= 17'd0;
      hex_cnt_r    <= 6'd0;
      dh_r         <= 64'd0;
      dl_r         <= 64'd0;
      line_st_r    <= ST_OK;
    end else begin
      phase_r      <= phase_nxt;
      tag_pos_r    <= tag_pos_nxt;
      neg_r        <= neg_nxt;
      digit_seen_r <= digit_seen_nxt;
      acc_r        <= acc_nxt;
      hex_cnt_r    <= hex_cnt_nxt;
      dh_r         <= dh_nxt;
      dl_r         <= dl_nxt;
      line_st_r    <= line_st_nxt;
    end
  end

endmodule

// ===== hdl/write_command_line_parser_core.sv =====
// Top level of the WRITE command line parser: input register, parser, result register.
// Depends on wclp_pkg and wclp_parser.
`timescale 1ns / 1ps

// Takes one character word per clock on the in_ channel while in_stall is low and returns
// one result word per line on the out_ channel, on the character flagged in_last. Each
// character passes an input register and then the parser, which updates its registered
// state as the character leaves that register, so the block sustains one character per
// clock while in_stall is low. The result word is loaded at the edge where the final
// character leaves the input register, and out_valid rises with that load, unless a
// stalled result still holds the result register. The result register lets characters of
// the next line keep flowing while a result waits; in_stall rises only when a final
// character is waiting and the result register is still full and stalled.
module write_command_line_parser_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_ch,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_blk_num,
  output logic [63:0]        out_data_high,
  output logic [63:0]        out_data_low
);
  import wclp_pkg::*;

  logic         in_v_r;
  logic [7:0]   in_ch_r;
  logic         in_last_r;
  logic         out_v_r;
  wclp_result_t out_res_r;
  wclp_result_t res;
  logic         adv;
  logic         in_take;
  logic         out_load;

  // Advance the held character unless it closes a line and the result slot is blocked
  assign adv      = in_v_r && (!in_last_r || !out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_take  = in_valid && !in_stall;
  assign out_load = adv && in_last_r;

  wclp_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (adv),
    .ch    (in_ch_r),
    .last  (in_last_r),
    .res   (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_take) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_ch_r   <= in_ch;
      in_last_r <= in_last;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_v_r;
  assign out_status    = out_res_r.status;
  assign out_blk_num   = out_res_r.block;
  assign out_data_high = out_res_r.data_high;
  assign out_data_low  = out_res_r.data_low;

endmodule

// ===== hdl/wclp_checker.sv =====
// Port-level checks for the WRITE command line parser, bound to the top level.
// Depends on wclp_pkg and write_command_line_parser_core.
`timescale 1ns / 1ps

module wclp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic signed [15:0] out_blk_num,
  input logic [63:0]        out_data_high,
  input logic [63:0]        out_data_low
);
  import wclp_pkg::*;

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid right after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_blk_num)
      && $stable(out_data_high) && $stable(out_data_low))
    else $error("stalled result word changed");

  // Input back-pressure only comes from a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while result side is free");

  // Data is zero unless the line parsed fully
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_data_high == 64'd0 && out_data_low == 64'd0)
    else $error("data present on a failed line");

  // No block number without a parsed number
  a_block_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_WRITE || out_status == ST_NO_BLOCK)
      |-> out_blk_num == 16'sd0)
    else $error("block number present without a parsed number");

endmodule

bind write_command_line_parser_core wclp_checker u_wclp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_blk_num   (out_blk_num),
  .out_data_high (out_data_high),
  .out_data_low  (out_data_low)
);
